// ===== design/mbps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Masked byte pattern search package
// Shared widths, reset values, register indexes and the configuration bundle.
// ----------------------------------------------------------------------------
package mbps_pkg;

    // Default and upper bound for the pattern length the block is built for.
    localparam int PATTERN_BYTES_MAX = 32;

    // Fixed field widths.
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int PATTERN_W   = 256;
    localparam int CARE_W      = 32;
    localparam int LEN_W       = 6;
    localparam int SPAN_W      = 16;
    localparam int ADDR_W      = 64;
    localparam int SEEN_W      = 17;
    localparam int PAT_IDX_W   = 5;

    // Register reset values.
    localparam logic [CARE_W-1:0] CARE_RESET = '1;
    localparam logic [LEN_W-1:0]  LEN_RESET  = 6'd1;
    localparam logic [SPAN_W-1:0] SPAN_RESET = 16'd1024;

    // Byte counter saturation value.
    localparam logic [SEEN_W-1:0] SEEN_MAX = '1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT_0_7   = 3'd0,
        CFG_PAT_8_15  = 3'd1,
        CFG_PAT_16_23 = 3'd2,
        CFG_PAT_24_31 = 3'd3,
        CFG_CARE_MASK = 3'd4,
        CFG_LENGTH    = 3'd5,
        CFG_SPAN      = 3'd6,
        CFG_BASE      = 3'd7
    } t_cfg_index;

    // Configuration bundle handed from the register file to the datapath.
    typedef struct packed {
        logic [PATTERN_W-1:0] pattern;
        logic [CARE_W-1:0]    care;
        logic [LEN_W-1:0]     length;
        logic [SPAN_W-1:0]    span;
        logic [ADDR_W-1:0]    base;
    } t_cfg;

endpackage

// ===== design/mbps_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Masked byte pattern search configuration registers
// Holds the pattern, care mask, length, span and base address registers.
// ----------------------------------------------------------------------------
module mbps_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [mbps_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mbps_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output mbps_pkg::t_cfg                 o_cfg
);
    import mbps_pkg::*;

    t_cfg r_cfg;

    // Register writes take effect at the next edge.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pattern <= '0;
            r_cfg.care    <= CARE_RESET;
            r_cfg.length  <= LEN_RESET;
            r_cfg.span    <= SPAN_RESET;
            r_cfg.base    <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_PAT_0_7:   r_cfg.pattern[63:0]    <= i_cfg_data;
                CFG_PAT_8_15:  r_cfg.pattern[127:64]  <= i_cfg_data;
                CFG_PAT_16_23: r_cfg.pattern[191:128] <= i_cfg_data;
                CFG_PAT_24_31: r_cfg.pattern[255:192] <= i_cfg_data;
                CFG_CARE_MASK: r_cfg.care   <= i_cfg_data[CARE_W-1:0];
                CFG_LENGTH:    r_cfg.length <= i_cfg_data[LEN_W-1:0];
                CFG_SPAN:      r_cfg.span   <= i_cfg_data[SPAN_W-1:0];
                CFG_BASE:      r_cfg.base   <= i_cfg_data;
                default:       r_cfg.base   <= r_cfg.base;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== design/mbps_match.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Masked byte pattern search window compare
// Compares the byte window against the pattern under the care mask.
// ----------------------------------------------------------------------------
module mbps_match #(
    parameter int MAX_PATTERN_BYTES = mbps_pkg::PATTERN_BYTES_MAX
) (
    input  logic [MAX_PATTERN_BYTES*8-1:0]   i_window,
    input  logic [mbps_pkg::PATTERN_W-1:0]   i_pattern,
    input  logic [mbps_pkg::CARE_W-1:0]      i_care,
    input  logic [mbps_pkg::LEN_W-1:0]       i_length,
    output logic                             o_hit
);
    import mbps_pkg::*;

    logic [MAX_PATTERN_BYTES-1:0] pos_ok;

    // Window position j holds the byte j items back; it lines up with
    // pattern byte length-1-j. Positions at or beyond the length never fail.
    always_comb begin
        logic [LEN_W-1:0]     k_full;
        logic [PAT_IDX_W-1:0] k;
        logic                 in_use;
        for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
            k_full    = i_length - LEN_W'(j) - LEN_W'(1);
            k         = k_full[PAT_IDX_W-1:0];
            in_use    = LEN_W'(j) < i_length;
            pos_ok[j] = !in_use || !i_care[k] ||
                        (i_window[j*8 +: 8] == i_pattern[{k, 3'b000} +: 8]);
        end
    end

    assign o_hit = &pos_ok;

endmodule

// ===== design/masked_byte_pattern_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Masked byte pattern search
// Streams memory bytes and reports the first masked pattern match address.
// ----------------------------------------------------------------------------
// The block takes one byte per clock with no gaps of its own: an accepted
// item is held in the input register while the masked window compare and
// the base plus offset add run on it, and any result that it closes is written
// into the output register when the pipeline advances. The combinational compare
// over the whole byte window sets the one-item-per-clock rate; the pipeline
// only stalls while a finished result waits to be taken.
// A scan begins with a byte marked scan_start and ends with exactly one
// result, either found with the match address or not found with address zero;
// bytes after that are dropped until the next scan_start.
module masked_byte_pattern_search #(
    parameter int MAX_PATTERN_BYTES = mbps_pkg::PATTERN_BYTES_MAX
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write port
    input  logic                            i_cfg_we,
    input  logic [mbps_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mbps_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Byte stream
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [7:0]                      i_data_byte,
    input  logic                            i_scan_start,
    input  logic                            i_stream_end,
    // Results
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_found,
    output logic [mbps_pkg::ADDR_W-1:0]     o_match_address
);
    import mbps_pkg::*;

    localparam int WIN_W = MAX_PATTERN_BYTES * 8;

    t_cfg cfg;

    // Input register
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_start;
    logic        r_in_end;

    // Scan state
    logic [WIN_W-1:0]  r_window;
    logic [WIN_W-1:0]  n_window;
    logic [SEEN_W-1:0] r_seen;
    logic [SEEN_W-1:0] n_seen;
    logic              r_done;
    logic              n_done;

    // Output register
    logic              r_out_valid;
    logic              r_found;
    logic [ADDR_W-1:0] r_addr;
    logic              n_out_valid;
    logic              n_found;
    logic [ADDR_W-1:0] n_addr;

    logic              advance;
    logic              process;
    logic              active;
    logic [SEEN_W-1:0] seen_cur;
    logic [LEN_W-1:0]  len_eff;
    logic [SEEN_W:0]   count_next;
    logic              have_off;
    logic [SEEN_W-1:0] offset;
    logic              in_span;
    logic              last_off;
    logic              hit;

    mbps_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // The pipeline moves whenever the output register is free or being taken.
    assign advance    = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || advance;
    assign process    = r_in_valid && advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte  <= i_data_byte;
            r_in_start <= i_scan_start;
            r_in_end   <= i_stream_end;
        end
    end

    // Effective pattern length, clamped to one through the window depth.
    always_comb begin
        if (cfg.length == '0) begin
            len_eff = LEN_W'(1);
        end else if (cfg.length > LEN_W'(MAX_PATTERN_BYTES)) begin
            len_eff = LEN_W'(MAX_PATTERN_BYTES);
        end else begin
            len_eff = cfg.length;
        end
    end

    // Window shifted by the current byte; position zero is the newest byte.
    always_comb begin
        n_window[7:0] = r_in_byte;
        for (int j = 1; j < MAX_PATTERN_BYTES; j++) begin
            n_window[j*8 +: 8] = r_window[(j-1)*8 +: 8];
        end
    end

    mbps_match #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
    ) u_match (
        .i_window  (n_window),
        .i_pattern (cfg.pattern),
        .i_care    (cfg.care),
        .i_length  (len_eff),
        .o_hit     (hit)
    );

    // Offset bookkeeping for the window this byte completes.
    always_comb begin
        seen_cur   = r_in_start ? '0 : r_seen;
        active     = r_in_start || !r_done;
        count_next = {1'b0, seen_cur} + (SEEN_W+1)'(1);
        have_off   = count_next >= (SEEN_W+1)'(len_eff);
        offset     = SEEN_W'(count_next - (SEEN_W+1)'(len_eff));
        in_span    = offset < SEEN_W'(cfg.span);
        last_off   = (cfg.span == '0) ||
                     (have_off && (count_next - (SEEN_W+1)'(len_eff) + (SEEN_W+1)'(1)
                                   >= (SEEN_W+1)'(cfg.span)));
    end

    // Next scan state and result.
    always_comb begin
        n_done      = r_done;
        n_seen      = r_seen;
        n_out_valid = 1'b0;
        n_found     = 1'b0;
        n_addr      = '0;
        if (process) begin
            if (r_in_start) begin
                n_done = 1'b0;
                n_seen = '0;
            end
            if (active) begin
                n_seen = (seen_cur == SEEN_MAX) ? seen_cur : seen_cur + SEEN_W'(1);
                if (have_off && in_span && hit) begin
                    n_done      = 1'b1;
                    n_out_valid = 1'b1;
                    n_found     = 1'b1;
                    n_addr      = cfg.base + ADDR_W'(offset);
                end else if (r_in_end || last_off) begin
                    n_done      = 1'b1;
                    n_out_valid = 1'b1;
                end
            end
        end
    end

    // Scan control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b1;
            r_seen <= '0;
        end else begin
            r_done <= n_done;
            r_seen <= n_seen;
        end
    end

    // Byte window only moves while a scan is running.
    always_ff @(posedge i_clk) begin
        if (process && active) begin
            r_window <= n_window;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && n_out_valid) begin
            r_found <= n_found;
            r_addr  <= n_addr;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_found         = r_found;
    assign o_match_address = r_addr;

endmodule

// ===== verif/tb_masked_byte_pattern_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Masked byte pattern search testbench
// Streams byte scans into the block with random bursts and gaps while the
// result side stalls on its own pattern. A local copy of the scan state predicts
// the random scans' results, directed rows type theirs, and all are checked in order.
// ----------------------------------------------------------------------------
module tb_masked_byte_pattern_search;

    import mbps_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_ITEMS  = 1230;
    localparam int PHASE_ITEMS   = 110;
    localparam int DIR_ROWS      = 36;

    // Kinds of rows in the directed table and how their result is judged.
    typedef enum logic {ROW_WRITE, ROW_BYTE} t_row_kind;
    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_HIT, CHK_MISS} t_row_check;

    typedef struct {
        t_row_kind   kind;
        t_cfg_index  reg_idx;
        logic [63:0] word;    // register value, or typed match address for a hit
        logic [7:0]  data;
        bit          start;
        bit          stop;
        t_row_check  chk;
    } t_dir_row;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] addr;
    } t_scan_result;

    // DUT ports.
    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index     = CFG_PAT_0_7;
    logic [CFG_DATA_W-1:0] i_cfg_data      = '0;
    logic                  i_in_valid      = 1'b0;
    logic                  o_in_ready;
    logic [7:0]            i_data_byte     = 8'h00;
    logic                  i_scan_start    = 1'b0;
    logic                  i_stream_end    = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready     = 1'b0;
    logic                  o_found;
    logic [ADDR_W-1:0]     o_match_address;

    // Local copy of the configuration registers.
    logic [63:0]       pat_word [4];
    logic [CARE_W-1:0] care_bits = CARE_RESET;
    logic [LEN_W-1:0]  len_reg   = LEN_RESET;
    logic [SPAN_W-1:0] span_reg  = SPAN_RESET;
    logic [ADDR_W-1:0] base_reg  = '0;

    // Local copy of the scan state.
    logic [7:0]  win [PATTERN_BYTES_MAX];
    int unsigned seen      = 0;
    bit          scan_idle = 1'b1;

    t_scan_result pending_results [$];
    t_scan_result want;

    int cycle_count    = 0;
    int mismatch_count = 0;
    int tx_burst_left  = 0;
    bit tx_gaps_on     = 1'b1;
    int hold_req_cnt   = 0;
    int hold_done_cnt  = 0;
    int rx_hold_left   = 0;
    logic [9:0] rx_cycle = '0;

    // Directed table: reset state, extremes, restart, stream end, zero span,
    // wildcards and out-of-range lengths.
    t_dir_row dir_rows [DIR_ROWS] = '{
        '{ROW_BYTE,  CFG_PAT_0_7,   64'h0,                  8'h00, 1'b0, 1'b0, CHK_NONE},
        '{ROW_BYTE,  CFG_PAT_0_7,   64'h0,                  8'h00, 1'b1, 1'b0, CHK_HIT},
        '{ROW_BYTE,  CFG_PAT_0_7,   64'h0,                  8'h55, 1'b0, 1'b0, CHK_NONE},
        '{ROW_WRITE, CFG_PAT_0_7,   64'h0000_0000_0000_CDAB, 8'h00, 1'b0, 1'b0, CHK_NONE},
        '{ROW_WRITE, CFG_LENGTH,    64'd2,                  8'h00, 1'b0, 1'b0, CHK_NONE},
        '{ROW_WRITE, CFG_SPAN,      64'd3,                  8'h00, 1'b0, 1'b0, CHK_NONE},
        '{ROW_WRITE, CFG_BASE,      64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, CHK_NONE},
        '{ROW_BYTE,  CFG_PAT_0_7,   64'h0,                  8'h12, 1'b1, 1'b0, CHK_NONE},
        '{ROW_BYTE,  CFG_PAT_0_7,   64'h0,                  8'hAB, 1'b0, 1'b0, CHK_NONE},
        '{ROW_BYTE,  CFG_PAT_0_7,   64'h0,                  8'hCD, 1'b0, 1'b0, CHK_HIT},
        '{ROW_BYTE,  CFG_PAT_0_7,   64'h0,                  8'hAB, 1'b1, 1'b0, CHK_NONE},
        '{ROW_BYTE,  CFG_PAT_0_7,   64'h0,                  8'h00, 1'b0, 1'b0, CHK_NONE},
        '{ROW_BYTE,  CFG_PAT_0_7,   64'h0,                  8'h00, 1'b0, 1'b0, CHK_NONE},
        '{ROW_BYTE,  CFG_PAT_0_7,   64'h0,                  8'h00, 1'b0, 1'b0, CHK_MISS},
        '{ROW_BYTE,  CFG_PAT_0_7,   64'h0,                  8'h00, 1'b1, 1'b0, CHK_NONE},
        '{ROW_BYTE,  CFG_PAT_0_7,   64'h0,                  8'hAB, 1'b1, 1'b0, CHK_NONE},
        '{ROW_BYTE,  CFG_PAT_0_7,   64'hFFFF_FFFF_FFFF_FFFF, 8'hCD, 1'b0, 1'b0, CHK_HIT},
        '{ROW_BYTE,  CFG_PAT_0_7,   64'h0,                  8'h00, 1'b1, 1'b0, CHK_NONE},
        '{ROW_BYTE,  CFG_PAT_0_7,   64'h0,                  8'h00, 1'b0, 1'b1, CHK_MISS},
        '{ROW_BYTE,  CFG_PAT_0_7,   64'h0,                  8'hAB, 1'b1, 1'b0, CHK_NONE},
        '{ROW_BYTE,  CFG_PAT_0_7,   64'hFFFF_FFFF_FFFF_FFFF, 8'hCD, 1'b0, 1'b1, CHK_HIT},
        '{ROW_WRITE, CFG_SPAN,      64'd0,                  8'h00, 1'b0, 1'b0, CHK_NONE},
        '{ROW_BYTE,  CFG_PAT_0_7,   64'h0,                  8'h7E, 1'b1, 1'b0, CHK_MISS},
        '{ROW_WRITE, CFG_CARE_MASK, 64'hFFFF_FFFF_0000_0000, 8'h00, 1'b0, 1'b0, CHK_NONE},
        '{ROW_WRITE, CFG_LENGTH,    64'hFFFF_FFFF_FFFF_FFC0, 8'h00, 1'b0, 1'b0, CHK_NONE},
        '{ROW_WRITE, CFG_SPAN,      64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, CHK_NONE},
        '{ROW_WRITE, CFG_BASE,      64'h8000_0000_0000_0000, 8'h00, 1'b0, 1'b0, CHK_NONE},
        '{ROW_BYTE,  CFG_PAT_0_7,   64'h8000_0000_0000_0000, 8'hFF, 1'b1, 1'b1, CHK_HIT},
        '{ROW_BYTE,  CFG_PAT_0_7,   64'h0,                  8'hFF, 1'b0, 1'b1, CHK_NONE},
        '{ROW_WRITE, CFG_PAT_8_15,  64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, CHK_NONE},
        '{ROW_WRITE, CFG_PAT_16_23, 64'h0123_4567_89AB_CDEF, 8'h00, 1'b0, 1'b0, CHK_NONE},
        '{ROW_WRITE, CFG_PAT_24_31, 64'hA5A5_A5A5_A5A5_A5A5, 8'h00, 1'b0, 1'b0, CHK_NONE},
        '{ROW_WRITE, CFG_CARE_MASK, 64'h0000_0000_FFFF_FFFF, 8'h00, 1'b0, 1'b0, CHK_NONE},
        '{ROW_WRITE, CFG_LENGTH,    64'h0000_0000_0000_003F, 8'h00, 1'b0, 1'b0, CHK_NONE},
        '{ROW_BYTE,  CFG_PAT_0_7,   64'h0,                  8'h00, 1'b1, 1'b0, CHK_NONE},
        '{ROW_BYTE,  CFG_PAT_0_7,   64'h0,                  8'hFF, 1'b0, 1'b1, CHK_MISS}
    };

    masked_byte_pattern_search u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_data_byte     (i_data_byte),
        .i_scan_start    (i_scan_start),
        .i_stream_end    (i_stream_end),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_found         (o_found),
        .o_match_address (o_match_address)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Pattern length in use: zero acts as one, anything above the window as the window.
    function automatic int unsigned eff_len();
        if (len_reg == '0)
            return 1;
        if (len_reg > PATTERN_BYTES_MAX)
            return PATTERN_BYTES_MAX;
        return len_reg;
    endfunction

    function automatic logic [7:0] pattern_byte(int unsigned k);
        return pat_word[k / 8][(k % 8) * 8 +: 8];
    endfunction

    // The oldest byte of the window lines up with pattern byte zero.
    function automatic bit window_hit(int unsigned plen);
        for (int unsigned k = 0; k < plen; k++) begin
            if (care_bits[k] && win[plen - 1 - k] !== pattern_byte(k))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Advances the scan by one byte and tells whether a result is due.
    function automatic void advance_scan(input logic [7:0] data, input bit start,
                                         input bit stop, output bit due,
                                         output t_scan_result res);
        int unsigned plen;
        int unsigned n;
        int unsigned off;
        bit          have_off;
        due  = 1'b0;
        res  = '0;
        if (start) begin
            seen      = 0;
            scan_idle = 1'b0;
        end
        if (scan_idle)
            return;
        for (int i = PATTERN_BYTES_MAX - 1; i > 0; i--)
            win[i] = win[i - 1];
        win[0] = data;
        plen = eff_len();
        n    = seen;
        if (seen < SEEN_MAX)
            seen++;
        have_off = (n + 1 >= plen);
        off      = have_off ? n + 1 - plen : 0;
        if (have_off && off < span_reg && window_hit(plen)) begin
            scan_idle = 1'b1;
            due       = 1'b1;
            res.found = 1'b1;
            res.addr  = base_reg + ADDR_W'(off);
            return;
        end
        // The last allowed window or the end of the stream closes the scan unmatched.
        if (stop || span_reg == '0 || (have_off && off + 1 >= span_reg)) begin
            scan_idle = 1'b1;
            due       = 1'b1;
        end
    endfunction

    task automatic flag_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    // Writes one register and mirrors it locally, then waits a clock with the write enable low.
    task automatic write_reg(input t_cfg_index idx, input logic [63:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_CARE_MASK: care_bits = value[CARE_W-1:0];
            CFG_LENGTH:    len_reg   = value[LEN_W-1:0];
            CFG_SPAN:      span_reg  = value[SPAN_W-1:0];
            CFG_BASE:      base_reg  = value;
            default:       pat_word[int'(idx)] = value;
        endcase
        @(posedge i_clk);
    endtask

    // Offers one byte in the current burst, waits for it to be taken, and
    // queues what it should produce.
    task automatic send_item(input logic [7:0] data, input bit start, input bit stop,
                             input t_row_check chk, input logic [63:0] typed_addr);
        t_scan_result res;
        bit           due;
        if (tx_burst_left == 0) begin
            tx_burst_left = $urandom_range(1, 24);
            if (tx_gaps_on && $urandom_range(0, 1) == 1) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
        tx_burst_left--;
        i_in_valid   <= 1'b1;
        i_data_byte  <= data;
        i_scan_start <= start;
        i_stream_end <= stop;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1)
            @(posedge i_clk);
        advance_scan(data, start, stop, due, res);
        case (chk)
            CHK_MODEL: if (due) pending_results.push_back(res);
            CHK_HIT:   pending_results.push_back('{1'b1, typed_addr});
            CHK_MISS:  pending_results.push_back('{1'b0, 64'd0});
            default:   ;
        endcase
    endtask

    // Stops offering and lets every outstanding result come out.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Picks a fresh setting; the unused upper data bits carry random junk.
    task automatic pick_config(input int phase_no);
        logic [63:0] value;
        for (int w = 0; w < 4; w++)
            write_reg(t_cfg_index'(w), {$urandom, $urandom});
        value = {$urandom, $urandom};
        case ($urandom_range(0, 4))
            0:       value[31:0] = '1;
            1:       value[31:0] = '0;
            2:       value[31:0] = $urandom & $urandom;
            default: ;
        endcase
        write_reg(CFG_CARE_MASK, value);
        value = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       value[5:0] = 6'd0;
            1:       value[5:0] = 6'($urandom_range(33, 63));
            2:       value[5:0] = 6'd32;
            3:       value[5:0] = 6'($urandom_range(9, 31));
            default: value[5:0] = 6'($urandom_range(1, 8));
        endcase
        write_reg(CFG_LENGTH, value);
        value = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       value[15:0] = 16'd0;
            1:       value[15:0] = 16'hFFFF;
            2:       value[15:0] = 16'd1;
            3:       value[15:0] = 16'($urandom_range(40, 300));
            default: value[15:0] = 16'($urandom_range(1, 40));
        endcase
        // The long receiver hold-off wants results coming fast.
        if (phase_no == 2)
            value[15:0] = 16'($urandom_range(1, 8));
        write_reg(CFG_SPAN, value);
        case ($urandom_range(0, 4))
            0:       value = '0;
            1:       value = '1;
            default: value = {$urandom, $urandom};
        endcase
        write_reg(CFG_BASE, value);
    endtask

    // One scan: a start byte and a body of pattern and random bytes, often with the
    // whole pattern planted, sometimes preceded by stray bytes and broken by a
    // restart or an early stream end. Every byte offered counts as an item.
    task automatic run_scan(inout int taken);
        logic [7:0]  seq [$];
        int unsigned plen;
        int unsigned cap;
        int unsigned n;
        int unsigned at;
        bit          end_last;
        plen = eff_len();
        cap  = plen + ((span_reg > 40) ? 40 : span_reg) + 3;
        n    = $urandom_range(1, cap);
        for (int unsigned i = 0; i < n; i++)
            seq.push_back(($urandom_range(0, 1) == 1) ?
                          pattern_byte($urandom_range(0, plen - 1)) : 8'($urandom));
        if (n >= plen && $urandom_range(0, 9) < 6) begin
            at = $urandom_range(0, n - plen);
            for (int unsigned k = 0; k < plen; k++)
                if (care_bits[k])
                    seq[at + k] = pattern_byte(k);
        end
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                send_item(8'($urandom), 1'b0, $urandom_range(0, 7) == 0, CHK_MODEL, 64'd0);
                taken++;
            end
        end
        end_last = $urandom_range(0, 1);
        for (int unsigned i = 0; i < n; i++) begin
            send_item(seq[i], i == 0 || $urandom_range(0, 29) == 0,
                      (i == n - 1 && end_last) || $urandom_range(0, 39) == 0,
                      CHK_MODEL, 64'd0);
            taken++;
        end
    endtask

    // Result side: ready follows a rotating pattern, and a requested hold-off
    // keeps it low for a long stretch.
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 1'b1;
        if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
            i_out_ready  <= 1'b0;
        end else if (hold_req_cnt != hold_done_cnt) begin
            hold_done_cnt <= hold_req_cnt;
            rx_hold_left  <= HOLD_CYCLES;
            i_out_ready   <= 1'b0;
        end else begin
            case (rx_cycle[9:8])
                2'd0:    i_out_ready <= 1'b1;
                2'd1:    i_out_ready <= ($urandom_range(0, 1) == 1);
                2'd2:    i_out_ready <= (rx_cycle[2:0] > 3'd2);
                default: i_out_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // Every taken result is matched against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (pending_results.size() == 0) begin
                flag_mismatch($sformatf("result with none expected: found %0b addr %h",
                                        o_found, o_match_address));
            end else begin
                want = pending_results.pop_front();
                if (o_found !== want.found)
                    flag_mismatch($sformatf("found %0b, expected %0b", o_found, want.found));
                if (o_match_address !== want.addr)
                    flag_mismatch($sformatf("address %h, expected %h",
                                            o_match_address, want.addr));
            end
        end
    end

    // Run limit.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin
        bit streaming;
        int random_taken;
        int phase_taken;
        int phase;
        streaming    = 1'b0;
        random_taken = 0;
        phase        = 0;
        foreach (pat_word[w])
            pat_word[w] = '0;
        foreach (win[i])
            win[i] = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table.
        for (int r = 0; r < DIR_ROWS; r++) begin
            if (dir_rows[r].kind == ROW_WRITE) begin
                if (streaming)
                    settle();
                streaming = 1'b0;
                write_reg(dir_rows[r].reg_idx, dir_rows[r].word);
            end else begin
                send_item(dir_rows[r].data, dir_rows[r].start, dir_rows[r].stop,
                          dir_rows[r].chk, dir_rows[r].word);
                streaming = 1'b1;
            end
        end

        // Random phases, each under its own setting.
        while (random_taken < RANDOM_ITEMS) begin
            phase++;
            settle();
            pick_config(phase);
            tx_gaps_on  = (phase == 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
            if (phase == 2)
                hold_req_cnt++;
            phase_taken = 0;
            while (phase_taken < PHASE_ITEMS && random_taken + phase_taken < RANDOM_ITEMS)
                run_scan(phase_taken);
            random_taken += phase_taken;
        end

        settle();
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
